@@ sv/hqp_pkg.sv @@
// hqp_pkg: shared sizes, register index, status and action codes for the
// quadratic-probe hash table core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hqp_pkg;

    localparam int HQP_SLOTS   = 64;
    localparam int HQP_IDX_W   = $clog2(HQP_SLOTS);
    localparam int HQP_M_W     = HQP_IDX_W + 1;
    localparam int HQP_CFG_W   = 7;
    localparam int HQP_KEY_W   = 16;
    localparam int HQP_VAL_W   = 32;
    localparam int HQP_POS_W   = 6;
    localparam int HQP_ST_W    = 2;
    localparam int HQP_ADDR_W  = 3;
    localparam int HQP_DATA_W  = 32;
    localparam int HQP_ENTRY_W = HQP_KEY_W + HQP_VAL_W;
    localparam int HQP_BIT_W   = $clog2(HQP_KEY_W);

    localparam logic [HQP_CFG_W-1:0] HQP_TABLE_SIZE_RST = HQP_CFG_W'(HQP_SLOTS);

    // register index, taken from the word address
    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic [HQP_ST_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [HQP_ST_W-1:0] ST_DELETED  = 2'd1;
    localparam logic [HQP_ST_W-1:0] ST_FAIL     = 2'd2;

    localparam logic       ACT_INSERT = 1'b0;
    localparam logic       ACT_DELETE = 1'b1;

endpackage

`default_nettype wire

@@ sv/hqp_ram.sv @@
// hqp_ram: generic single-write, single-read RAM with registered read data
// self-contained, no package needed
`timescale 1ns / 1ps
`default_nettype none

module hqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/hash_table_quadratic_probe_core.sv @@
// hash_table_quadratic_probe_core: open-addressing hash table with quadratic probing
// one shared modular adder reduces the key and steps the probe; needs hqp_pkg and hqp_ram
// key mod m comes first, then one probe per cycle on insert (1..m+1 probes); on delete
//   an empty slot takes S_PROBE only, an occupied one S_PROBE then S_CHECK; done follows the last probe
// throughput: one item at a time, busy from start until done
// reset: all slots empty, table_size = 64, no clearing pass; done cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module hash_table_quadratic_probe_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hqp_pkg::HQP_ADDR_W-1:0]      paddr,
    input  wire logic [hqp_pkg::HQP_DATA_W-1:0]      pwdata,
    output logic      [hqp_pkg::HQP_DATA_W-1:0]      prdata,
    output logic                                     pready,
    // command
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                action,
    input  wire logic [hqp_pkg::HQP_KEY_W-1:0]       search_key,
    input  wire logic signed [hqp_pkg::HQP_VAL_W-1:0] new_value,
    // result
    output logic                                     done,
    output logic      [hqp_pkg::HQP_ST_W-1:0]        status,
    output logic      [hqp_pkg::HQP_POS_W-1:0]       position,
    output logic signed [hqp_pkg::HQP_VAL_W-1:0]     removed_value
);

    import hqp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [HQP_CFG_W-1:0]   table_size_reg, table_size_next;
    logic [HQP_SLOTS-1:0]   valid_reg, valid_next;

    logic                   action_reg, action_next;
    logic [HQP_KEY_W-1:0]   key_reg, key_next;
    logic [HQP_VAL_W-1:0]   value_reg, value_next;
    logic [HQP_M_W-1:0]     m_reg, m_next;
    logic [HQP_M_W-1:0]     cnt_reg, cnt_next;
    logic [HQP_BIT_W-1:0]   bit_reg, bit_next;
    logic [HQP_IDX_W-1:0]   p_reg, p_next;
    logic [HQP_IDX_W-1:0]   inc_reg, inc_next;

    logic                   done_reg, done_next;
    logic [HQP_ST_W-1:0]    status_reg, status_next;
    logic [HQP_POS_W-1:0]   position_reg, position_next;
    logic [HQP_VAL_W-1:0]   removed_reg, removed_next;

    // shared modular adder: (a + b + cin) mod m with a, b below m
    logic [HQP_IDX_W-1:0]   unit_a, unit_b;
    logic                   unit_cin;
    logic [HQP_M_W-1:0]     unit_sum;
    logic [HQP_M_W-1:0]     unit_red;
    logic [HQP_IDX_W-1:0]   unit_out;

    // odd-step increment, kept reduced mod m
    logic [HQP_M_W-1:0]     inc_t0, inc_t1, inc_t2;
    logic [HQP_IDX_W-1:0]   inc_step;

    logic [HQP_M_W-1:0]     m_start;
    logic                   cfg_write;

    logic                   ram_we;
    logic [HQP_ENTRY_W-1:0] ram_wdata;
    logic [HQP_ENTRY_W-1:0] ram_rdata;

    hqp_ram #(
        .WIDTH (HQP_ENTRY_W),
        .DEPTH (HQP_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (p_reg),
        .wdata (ram_wdata),
        .raddr (p_reg),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {key_reg, value_reg};

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TABLE_SIZE) ? HQP_DATA_W'(table_size_reg) : '0;

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_write && (paddr[2] == REG_TABLE_SIZE))
        begin
            table_size_next = pwdata[HQP_CFG_W-1:0];
        end
    end

    // modulus clamped to 1..slots
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            m_start = HQP_M_W'(1);
        end
        else if (HQP_M_W'(table_size_reg) > HQP_M_W'(HQP_SLOTS))
        begin
            m_start = HQP_M_W'(HQP_SLOTS);
        end
        else
        begin
            m_start = HQP_M_W'(table_size_reg);
        end
    end

    always_comb
    begin
        unit_a   = p_reg;
        unit_b   = (state_reg == S_DIV) ? p_reg : inc_reg;
        unit_cin = (state_reg == S_DIV) ? key_reg[bit_reg] : 1'b0;
        unit_sum = HQP_M_W'(unit_a) + HQP_M_W'(unit_b) + HQP_M_W'(unit_cin);
        unit_red = (unit_sum >= m_reg) ? unit_sum - m_reg : unit_sum;
        unit_out = unit_red[HQP_IDX_W-1:0];
    end

    // (i+1)^2 - i^2 grows by two each probe; two reductions cover m = 1
    always_comb
    begin
        inc_t0   = HQP_M_W'(inc_reg) + HQP_M_W'(2);
        inc_t1   = (inc_t0 >= m_reg) ? inc_t0 - m_reg : inc_t0;
        inc_t2   = (inc_t1 >= m_reg) ? inc_t1 - m_reg : inc_t1;
        inc_step = inc_t2[HQP_IDX_W-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        action_next   = action_reg;
        key_next      = key_reg;
        value_next    = value_reg;
        m_next        = m_reg;
        cnt_next      = cnt_reg;
        bit_next      = bit_reg;
        p_next        = p_reg;
        inc_next      = inc_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        position_next = position_reg;
        removed_next  = removed_reg;
        ram_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    key_next    = search_key;
                    value_next  = new_value;
                    m_next      = m_start;
                    cnt_next    = '0;
                    bit_next    = HQP_BIT_W'(HQP_KEY_W - 1);
                    p_next      = '0;
                    inc_next    = (m_start == HQP_M_W'(1)) ? '0 : HQP_IDX_W'(1);
                    state_next  = S_DIV;
                end
            end

            S_DIV:
            begin
                // restoring remainder, one key bit per cycle, msb first
                p_next = unit_out;
                if (bit_reg == '0)
                begin
                    state_next = S_PROBE;
                end
                else
                begin
                    bit_next = bit_reg - HQP_BIT_W'(1);
                end
            end

            S_PROBE:
            begin
                if (action_reg == ACT_INSERT)
                begin
                    if (!valid_reg[p_reg])
                    begin
                        ram_we            = 1'b1;
                        valid_next[p_reg] = 1'b1;
                        done_next         = 1'b1;
                        status_next       = ST_INSERTED;
                        position_next     = HQP_POS_W'(p_reg);
                        removed_next      = '0;
                        state_next        = S_IDLE;
                    end
                end
                else if (valid_reg[p_reg])
                begin
                    // key read issued on p_reg, compared next cycle
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (ram_rdata[HQP_ENTRY_W-1:HQP_VAL_W] == key_reg)
                begin
                    valid_next[p_reg] = 1'b0;
                    done_next         = 1'b1;
                    status_next       = ST_DELETED;
                    position_next     = HQP_POS_W'(p_reg);
                    removed_next      = ram_rdata[HQP_VAL_W-1:0];
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // probe missed: step to the next slot or give up after m+1 probes
        if (((state_reg == S_PROBE) && (valid_reg[p_reg] == (action_reg == ACT_INSERT)))
            || ((state_reg == S_CHECK)
                && (ram_rdata[HQP_ENTRY_W-1:HQP_VAL_W] != key_reg)))
        begin
            if (cnt_reg == m_reg)
            begin
                done_next     = 1'b1;
                status_next   = ST_FAIL;
                position_next = '0;
                removed_next  = '0;
                state_next    = S_IDLE;
            end
            else
            begin
                p_next     = unit_out;
                inc_next   = inc_step;
                cnt_next   = cnt_reg + HQP_M_W'(1);
                state_next = S_PROBE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= HQP_TABLE_SIZE_RST;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            table_size_reg <= table_size_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        m_reg        <= m_next;
        cnt_reg      <= cnt_next;
        bit_reg      <= bit_next;
        p_reg        <= p_next;
        inc_reg      <= inc_next;
        status_reg   <= status_next;
        position_reg <= position_next;
        removed_reg  <= removed_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign position      = position_reg;
    assign removed_value = removed_reg;

endmodule

`default_nettype wire
